### rtl/playfair_digraph_cipher_core_assert.svh
// assertion macros used by the playfair core datapath
`ifndef PLAYFAIR_DIGRAPH_CIPHER_CORE_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// checked on clk_i, off while rst_ni is low
`define PFC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked on clk_i at every edge, reset included
`define PFC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define PFC_ASSERT(name, prop, msg)
`define PFC_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

### rtl/pfc_pkg.sv
// shared types, constants and helper functions of the playfair core
package pfc_pkg;

  localparam int unsigned SqSide     = 5;
  localparam int unsigned SqCells    = 25;
  localparam int unsigned NumLetters = 26;

  localparam logic [4:0] CodeI = 5'd8;
  localparam logic [4:0] CodeJ = 5'd9;
  localparam logic [4:0] CodeX = 5'd23;

  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_KEY    = 3'd1,
    ACT_FINISH = 3'd2,
    ACT_MSG    = 3'd3,
    ACT_END    = 3'd4
  } action_e;

  typedef struct packed {
    logic [2:0] action;
    logic [4:0] letter;
  } in_item_t;

  typedef struct packed {
    logic [4:0] letter_out;
    logic       pair_last;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic place_key;
    logic walk_start;
    logic place_walk;
    logic hold_load;
    logic hold_clear;
    logic pos_rd;
    logic pad_x;
    logic cell_rd;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic letter_ok;
    logic held_valid;
    logic held_match;
    logic walk_done;
    logic out_empty;
  } dp_status_t;

  function automatic logic [4:0] fold_j(input logic [4:0] code);
    fold_j = (code == CodeJ) ? CodeI : code;
  endfunction

  function automatic logic [2:0] pos_row(input logic [4:0] pos);
    if (pos >= 5'd20)      pos_row = 3'd4;
    else if (pos >= 5'd15) pos_row = 3'd3;
    else if (pos >= 5'd10) pos_row = 3'd2;
    else if (pos >= 5'd5)  pos_row = 3'd1;
    else                   pos_row = 3'd0;
  endfunction

  function automatic logic [2:0] pos_col(input logic [4:0] pos);
    logic [4:0] base;
    base    = {2'b00, pos_row(pos)} * 5'(SqSide);
    pos_col = 3'(pos - base);
  endfunction

  function automatic logic [4:0] cell_idx(input logic [2:0] row, input logic [2:0] col);
    cell_idx = {2'b00, row} * 5'(SqSide) + {2'b00, col};
  endfunction

  // one step along a row or column, wrapping at the square edge
  function automatic logic [2:0] shift_rc(input logic [2:0] v, input logic back);
    if (back) shift_rc = (v == 3'd0) ? 3'(SqSide - 1) : v - 3'd1;
    else      shift_rc = (v == 3'(SqSide - 1)) ? 3'd0 : v + 3'd1;
  endfunction

endpackage

### rtl/pfc_ctrl.sv
// controller state machine of the playfair core
module pfc_ctrl import pfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] action_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FILL = 4'b0010,
    ST_LOOK = 4'b0100,
    ST_CELL = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (action_e'(action_i))
            ACT_CLEAR: cmd_o.clear = 1'b1;
            ACT_KEY: cmd_o.place_key = status_i.letter_ok;
            ACT_FINISH: begin
              cmd_o.walk_start = 1'b1;
              state_d          = ST_FILL;
            end
            ACT_MSG: begin
              if (status_i.letter_ok) begin
                if (!status_i.held_valid) begin
                  cmd_o.hold_load = 1'b1;
                end else begin
                  cmd_o.pos_rd     = 1'b1;
                  cmd_o.pad_x      = status_i.held_match;
                  cmd_o.hold_clear = !status_i.held_match;
                  state_d          = ST_LOOK;
                end
              end
            end
            ACT_END: begin
              if (status_i.held_valid) begin
                cmd_o.pos_rd     = 1'b1;
                cmd_o.pad_x      = 1'b1;
                cmd_o.hold_clear = 1'b1;
                state_d          = ST_LOOK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        cmd_o.place_walk = 1'b1;
        if (status_i.walk_done) state_d = ST_IDLE;
      end
      ST_LOOK: begin
        cmd_o.cell_rd = 1'b1;
        state_d       = ST_CELL;
      end
      ST_CELL: begin
        // hold the cell data until the output buffer has drained
        if (status_i.out_empty) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/pfc_datapath.sv
// key square, letter positions, pair lookup and output buffer
`include "playfair_digraph_cipher_core_assert.svh"

module pfc_datapath import pfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  input  in_item_t   in_item_i,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o
);

  logic [4:0]  pos_mem  [NumLetters];
  logic [4:0]  cell_mem [SqCells];

  logic [25:0] present_q;
  logic [4:0]  fill_q;
  logic [4:0]  walk_q;
  logic        held_valid_q;
  logic [4:0]  held_q;
  logic        decrypt_q;

  logic        pres_a_q, pres_b_q;
  logic [4:0]  pos_a_q, pos_b_q;
  logic        cell_ok_a_q, cell_ok_b_q;
  logic [4:0]  cell_a_q, cell_b_q;
  logic [1:0]  out_cnt_q;
  logic [4:0]  out_a_q, out_b_q;

  logic [4:0]  in_code;
  logic [4:0]  code_b;
  logic [4:0]  place_code;
  logic        place_req;
  logic        place_en;

  assign in_code = fold_j(in_item_i.letter);
  assign code_b  = cmd_i.pad_x ? CodeX : in_code;

  // key placement, shared by key letters and the finishing walk
  assign place_code = cmd_i.place_walk ? walk_q : in_code;
  assign place_req  = cmd_i.place_key || (cmd_i.place_walk && (walk_q != CodeJ));
  assign place_en   = place_req && (place_code < 5'(NumLetters)) &&
                      (fill_q < 5'(SqCells)) && !present_q[place_code];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q    <= '0;
      fill_q       <= '0;
      walk_q       <= '0;
      held_valid_q <= 1'b0;
      held_q       <= '0;
      decrypt_q    <= 1'b0;
    end else begin
      if (cfg_we_i) decrypt_q <= cfg_data_i;
      if (cmd_i.walk_start) begin
        walk_q <= '0;
      end else if (cmd_i.place_walk) begin
        walk_q <= walk_q + 5'd1;
      end
      if (cmd_i.clear) begin
        present_q    <= '0;
        fill_q       <= '0;
        held_valid_q <= 1'b0;
        held_q       <= '0;
      end else begin
        if (place_en) begin
          present_q[place_code] <= 1'b1;
          fill_q                <= fill_q + 5'd1;
        end
        if (cmd_i.hold_load) begin
          held_valid_q <= 1'b1;
          held_q       <= in_code;
        end else if (cmd_i.hold_clear) begin
          held_valid_q <= 1'b0;
          held_q       <= '0;
        end
      end
    end
  end

  // position memory: written on placement, read for both pair letters
  always_ff @(posedge clk_i) begin
    if (place_en) pos_mem[place_code] <= fill_q;
    if (cmd_i.pos_rd) begin
      pos_a_q  <= pos_mem[held_q];
      pos_b_q  <= pos_mem[code_b];
      pres_a_q <= present_q[held_q];
      pres_b_q <= present_q[code_b];
    end
  end

  // pair rules on the looked-up positions
  logic [4:0] pa, pb;
  logic [2:0] ra, ca, rb, cb;
  logic [4:0] o1, o2;

  assign pa = pres_a_q ? pos_a_q : 5'd0;
  assign pb = pres_b_q ? pos_b_q : 5'd0;
  assign ra = pos_row(pa);
  assign ca = pos_col(pa);
  assign rb = pos_row(pb);
  assign cb = pos_col(pb);

  always_comb begin
    if (ra == rb) begin
      o1 = cell_idx(ra, shift_rc(ca, decrypt_q));
      o2 = cell_idx(rb, shift_rc(cb, decrypt_q));
    end else if (ca == cb) begin
      o1 = cell_idx(shift_rc(ra, decrypt_q), ca);
      o2 = cell_idx(shift_rc(rb, decrypt_q), cb);
    end else begin
      o1 = cell_idx(ra, cb);
      o2 = cell_idx(rb, ca);
    end
  end

  // square memory: cells below the fill count hold valid letters
  always_ff @(posedge clk_i) begin
    if (place_en) cell_mem[fill_q] <= place_code;
    if (cmd_i.cell_rd) begin
      cell_a_q    <= cell_mem[o1];
      cell_b_q    <= cell_mem[o2];
      cell_ok_a_q <= (o1 < fill_q);
      cell_ok_b_q <= (o2 < fill_q);
    end
  end

  // output buffer for one pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= '0;
    end else if (cmd_i.out_load) begin
      out_cnt_q <= 2'd2;
    end else if (out_valid_o && out_ready_i) begin
      out_cnt_q <= out_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_a_q <= cell_ok_a_q ? cell_a_q : 5'd0;
      out_b_q <= cell_ok_b_q ? cell_b_q : 5'd0;
    end
  end

  assign out_valid_o           = (out_cnt_q != 2'd0);
  assign out_item_o.letter_out = (out_cnt_q == 2'd2) ? out_a_q : out_b_q;
  assign out_item_o.pair_last  = (out_cnt_q == 2'd1);

  assign status_o.letter_ok  = (in_item_i.letter < 5'(NumLetters));
  assign status_o.held_valid = held_valid_q;
  assign status_o.held_match = (held_q == in_code);
  assign status_o.walk_done  = (walk_q == 5'(NumLetters - 1));
  assign status_o.out_empty  = (out_cnt_q == 2'd0);

  `PFC_ASSERT_ALWAYS(a_fill_bound, !rst_ni || (fill_q <= 5'(SqCells)), "fill count beyond square size")
  `PFC_ASSERT(a_load_empty, cmd_i.out_load |-> out_cnt_q == 2'd0, "pair loaded over pending output")
  `PFC_ASSERT(a_load_two, cmd_i.out_load |=> out_cnt_q == 2'd2, "loaded pair not presented")
  `PFC_ASSERT(a_cnt_range, out_cnt_q != 2'd3, "output count out of range")

endmodule

### rtl/playfair_digraph_cipher_core.sv
// Playfair cipher core over a 5x5 key square. Key letters (J folded to I,
// repeats skipped) fill the square in order; finish key walks A..Z once, one
// letter per cycle, appending unused letters (no J). Clear, key letter and a
// first message letter are taken in idle. A message letter that completes a
// pair, or message end with a letter held, reads both letter positions on
// acceptance; the look state applies the row, column or rectangle rule and
// reads the two square cells; the cell state moves the pair into the output
// buffer. The two result letters then leave over two output transactions
// (pair_last marks the second) while the next input is already taken; a new
// pair waits only if the previous one has not yet drained. decrypt_mode
// selects backward shifts; the user must write it through the cfg port while
// idle (not enforced by the core). No clearing pass is needed after reset.
module playfair_digraph_cipher_core import pfc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  pfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (in_item_i.action),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pfc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the playfair digraph cipher core
module tb_top;
  import pfc_pkg::*;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned LongHold     = 200;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  // predicted key square, pending message letter and mode
  logic [4:0]            sq_cell [SqCells];
  logic [4:0]            sq_pos  [NumLetters];
  logic [NumLetters-1:0] placed;
  logic [4:0]            n_filled;
  logic                  pend_valid;
  logic [4:0]            pend_letter;
  logic                  decrypt_sel = 1'b0;
  out_item_t             cipher_q [$];
  out_item_t             want_item;

  int unsigned err_cnt        = 0;
  int unsigned items_sent     = 0;
  int unsigned letters_seen   = 0;
  int unsigned idle_cnt       = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;

  always #10 clk = ~clk;

  playfair_digraph_cipher_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  function automatic logic [4:0] ltr(input byte c);
    return 5'(c - "A");
  endfunction

  function automatic void square_clear();
    foreach (sq_cell[i]) sq_cell[i] = '0;
    foreach (sq_pos[i]) sq_pos[i] = '0;
    placed      = '0;
    n_filled    = '0;
    pend_valid  = 1'b0;
    pend_letter = '0;
  endfunction

  function automatic void square_place(input logic [4:0] code);
    if (code >= NumLetters || n_filled >= SqCells || placed[code]) return;
    sq_cell[n_filled] = code;
    sq_pos[code]      = n_filled;
    placed[code]      = 1'b1;
    n_filled          = n_filled + 5'd1;
  endfunction

  function automatic logic [4:0] fold_letter(input logic [4:0] code);
    return (code == CodeJ) ? CodeI : code;
  endfunction

  // row, column or rectangle rule on one letter pair
  function automatic void cipher_pair(input logic [4:0] a, input logic [4:0] b);
    int unsigned pa, pb, r1, c1, r2, c2, shift, o1, o2;
    out_item_t   res;
    pa    = sq_pos[a] % SqCells;
    pb    = sq_pos[b] % SqCells;
    r1    = pa / SqSide;
    c1    = pa % SqSide;
    r2    = pb / SqSide;
    c2    = pb % SqSide;
    shift = decrypt_sel ? SqSide - 1 : 1;
    if (r1 == r2) begin
      o1 = r1 * SqSide + (c1 + shift) % SqSide;
      o2 = r2 * SqSide + (c2 + shift) % SqSide;
    end else if (c1 == c2) begin
      o1 = ((r1 + shift) % SqSide) * SqSide + c1;
      o2 = ((r2 + shift) % SqSide) * SqSide + c2;
    end else begin
      o1 = r1 * SqSide + c2;
      o2 = r2 * SqSide + c1;
    end
    res.letter_out = sq_cell[o1];
    res.pair_last  = 1'b0;
    cipher_q.push_back(res);
    res.letter_out = sq_cell[o2];
    res.pair_last  = 1'b1;
    cipher_q.push_back(res);
  endfunction

  function automatic void cipher_predict(input in_item_t it);
    logic [4:0] code;
    code = it.letter;
    case (it.action)
      ACT_CLEAR: square_clear();
      ACT_KEY: begin
        if (code < NumLetters) square_place(fold_letter(code));
      end
      ACT_FINISH: begin
        for (int k = 0; k < NumLetters; k++)
          if (k != CodeJ) square_place(5'(k));
      end
      ACT_MSG: begin
        if (code < NumLetters) begin
          code = fold_letter(code);
          if (!pend_valid) begin
            pend_valid  = 1'b1;
            pend_letter = code;
          end else if (pend_letter == code) begin
            // doubled letter: split with X, the new letter stays pending
            cipher_pair(pend_letter, CodeX);
          end else begin
            cipher_pair(pend_letter, code);
            pend_valid  = 1'b0;
            pend_letter = '0;
          end
        end
      end
      ACT_END: begin
        if (pend_valid) begin
          cipher_pair(pend_letter, CodeX);
          pend_valid  = 1'b0;
          pend_letter = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_item(input logic [2:0] act, input logic [4:0] letter);
    int unsigned gap;
    in_item_t    it;
    gap       = 0;
    it.action = act;
    it.letter = letter;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cipher_predict(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (cipher_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_mode(input logic mode);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    decrypt_sel = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [4:0] random_letter();
    if ($urandom_range(19) == 0) return 5'($urandom_range(31, 26));
    return 5'($urandom_range(25));
  endfunction

  // clear, key, finish, message, end; sometimes broken or followed by noise
  task automatic send_random_session();
    int unsigned n_key, n_msg, n_noise, pick;
    logic [4:0]  prev, cur;
    n_key   = $urandom_range(30);
    n_msg   = $urandom_range(40, 1);
    n_noise = $urandom_range(3);
    prev    = ltr("A");
    send_item(ACT_CLEAR, 5'($urandom));
    repeat (n_key) send_item(ACT_KEY, random_letter());
    if ($urandom_range(9) != 0) send_item(ACT_FINISH, 5'($urandom));
    repeat (n_msg) begin
      pick = $urandom_range(99);
      if (pick < 20) cur = prev;
      else if (pick < 30) cur = CodeX;
      else if (pick < 35) cur = CodeJ;
      else cur = random_letter();
      send_item(ACT_MSG, cur);
      prev = cur;
    end
    if ($urandom_range(3) != 0) send_item(ACT_END, 5'($urandom));
    repeat (n_noise) send_item(3'($urandom_range(7)), 5'($urandom));
  endtask

  task automatic test_empty_square();
    send_item(ACT_MSG, CodeJ);
    send_item(ACT_MSG, 5'd31);
    send_item(ACT_MSG, ltr("Z"));
    send_item(ACT_KEY, 5'd31);
    send_item(ACT_MSG, ltr("A"));
    send_item(ACT_END, 5'd0);
    send_item(ACT_END, 5'd31);
    send_item(3'd7, 5'd31);
    wait_drained();
  endtask

  task automatic test_key_rules();
    send_item(ACT_CLEAR, 5'd0);
    send_item(ACT_KEY, CodeJ);
    send_item(ACT_KEY, CodeI);
    send_item(ACT_KEY, ltr("M"));
    send_item(ACT_KEY, ltr("O"));
    send_item(ACT_KEY, ltr("N"));
    send_item(ACT_KEY, ltr("A"));
    send_item(ACT_KEY, ltr("R"));
    send_item(ACT_KEY, ltr("C"));
    send_item(ACT_KEY, ltr("H"));
    send_item(ACT_FINISH, 5'd0);
    send_item(ACT_FINISH, 5'd0);
    send_item(ACT_KEY, ltr("Z"));
    wait_drained();
  endtask

  task automatic test_message_rules();
    send_item(ACT_MSG, CodeX);
    send_item(ACT_MSG, CodeX);
    send_item(ACT_END, 5'd0);
    send_item(ACT_MSG, ltr("L"));
    send_item(ACT_MSG, ltr("L"));
    send_item(ACT_MSG, ltr("O"));
    send_item(ACT_MSG, CodeJ);
    send_item(ACT_MSG, ltr("K"));
    send_item(ACT_MSG, ltr("A"));
    send_item(ACT_END, 5'd0);
    wait_drained();
  endtask

  task automatic test_decrypt_mode();
    write_mode(1'b1);
    send_item(ACT_MSG, ltr("M"));
    send_item(ACT_MSG, ltr("C"));
    send_item(ACT_MSG, ltr("Z"));
    send_item(ACT_END, 5'd0);
    write_mode(1'b0);
  endtask

  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input logic mode, input int unsigned n_items);
    int unsigned start;
    write_mode(mode);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start          = items_sent;
    while (items_sent - start < n_items) send_random_session();
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering pairs
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(ACT_CLEAR, 5'd0);
    send_item(ACT_FINISH, 5'd0);
    hold_left = LongHold;
    repeat (40) send_item(ACT_MSG, 5'($urandom_range(25)));
    send_item(ACT_END, 5'd0);
    wait_drained();
  endtask

  task automatic test_pause_until_drained();
    repeat (6) send_item(ACT_MSG, 5'($urandom_range(25)));
    in_valid <= 1'b0;
    while (cipher_q.size() != 0) @(negedge clk);
    repeat (6) send_item(ACT_MSG, 5'($urandom_range(25)));
    send_item(ACT_END, 5'd0);
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      letters_seen++;
      if (cipher_q.size() == 0) begin
        err_cnt++;
        $error("unexpected result: letter_out %0d pair_last %0d",
               out_item.letter_out, out_item.pair_last);
      end else begin
        want_item = cipher_q.pop_front();
        if (out_item.letter_out !== want_item.letter_out) begin
          err_cnt++;
          $error("letter_out mismatch: expected %0d, actual %0d",
                 want_item.letter_out, out_item.letter_out);
        end
        if (out_item.pair_last !== want_item.pair_last) begin
          err_cnt++;
          $error("pair_last mismatch: expected %0d, actual %0d",
                 want_item.pair_last, out_item.pair_last);
        end
      end
    end
  end

  // counts cycles with no transaction on any channel, ends the run at IdleLimit
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt >= IdleLimit) begin
        $error("no transaction for %0d cycles, %0d results outstanding",
               idle_cnt, cipher_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    square_clear();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_square();
    test_key_rules();
    test_message_rules();
    test_decrypt_mode();
    test_random_phase(0, 0, 1'b0, 310);
    test_random_phase(54, 0, 1'b1, 310);
    test_random_phase(0, 54, 1'b0, 310);
    test_random_phase(27, 27, 1'b1, 310);
    test_output_backpressure();
    test_pause_until_drained();
    wait_drained();
    $display("Run covered %0d input transactions and %0d result letters checked,",
             items_sent, letters_seen);
    $display("both cipher directions, partial and full key squares, idling and backpressure.");
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
